FILE: hw/rtl/dhoat_pkg.sv
// Shared types, codes and the prime list for the double-hash table.
package dhoat_pkg;

    // Width of a table size and of a slot number on the ports.
    localparam int SIZE_W = 13;
    // Width of the running entry count.
    localparam int COUNT_W = 14;
    // Width of the hash that feeds the remainder unit.
    localparam int HASH_W = 32;
    // Number of listed table sizes.
    localparam int PRIME_COUNT = 16;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_RESIZE = 2'd2,
        CMD_UNUSED = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_READY = 3'd1,
        ST_FULL      = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_TOO_BIG   = 3'd4,
        ST_NO_SLOT   = 3'd5
    } result_code_t;

    // Listed table sizes, all prime, in rising order.
    function automatic logic [SIZE_W-1:0] prime_at(input logic [3:0] idx);
        logic [SIZE_W-1:0] p;
        begin
            case (idx)
                4'd0:    p = 13'd127;
                4'd1:    p = 13'd251;
                4'd2:    p = 13'd509;
                4'd3:    p = 13'd761;
                4'd4:    p = 13'd1021;
                4'd5:    p = 13'd1279;
                4'd6:    p = 13'd1531;
                4'd7:    p = 13'd1789;
                4'd8:    p = 13'd2039;
                4'd9:    p = 13'd2557;
                4'd10:   p = 13'd3067;
                4'd11:   p = 13'd4093;
                4'd12:   p = 13'd5119;
                4'd13:   p = 13'd6143;
                4'd14:   p = 13'd7159;
                default: p = 13'd8191;
            endcase
            return p;
        end
    endfunction

endpackage

FILE: hw/rtl/dhoat_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module dhoat_ram #(
    parameter int WIDTH = 81,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hw/rtl/dhoat_rem.sv
// Bit-serial remainder unit: one hash divided by two divisors at once.
module dhoat_rem
    import dhoat_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [HASH_W-1:0] dividend,
    input  logic [SIZE_W-1:0] div_a,
    input  logic [SIZE_W-1:0] div_b,
    output logic              done,
    output logic [SIZE_W-1:0] rem_a,
    output logic [SIZE_W-1:0] rem_b
);

    localparam int CNT_W = $clog2(HASH_W);

    logic [HASH_W-1:0] shift_reg;
    logic [SIZE_W-1:0] ra_reg;
    logic [SIZE_W-1:0] rb_reg;
    logic [SIZE_W-1:0] da_reg;
    logic [SIZE_W-1:0] db_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [SIZE_W:0]   ta;
    logic [SIZE_W:0]   tb;
    logic [SIZE_W-1:0] ra_next;
    logic [SIZE_W-1:0] rb_next;

    // One restoring step per cycle for each divisor.
    always_comb
    begin
        ta = {ra_reg, shift_reg[HASH_W-1]};
        tb = {rb_reg, shift_reg[HASH_W-1]};
        if (ta >= {1'b0, da_reg})
        begin
            ta = ta - {1'b0, da_reg};
        end
        if (tb >= {1'b0, db_reg})
        begin
            tb = tb - {1'b0, db_reg};
        end
        ra_next = ta[SIZE_W-1:0];
        rb_next = tb[SIZE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                cnt_reg   <= '0;
                shift_reg <= dividend;
                ra_reg    <= '0;
                rb_reg    <= '0;
                da_reg    <= div_a;
                db_reg    <= div_b;
            end
            else if (busy_reg)
            begin
                ra_reg    <= ra_next;
                rb_reg    <= rb_next;
                shift_reg <= {shift_reg[HASH_W-2:0], 1'b0};
                cnt_reg   <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(HASH_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done  = done_reg;
    assign rem_a = ra_reg;
    assign rem_b = rb_reg;

endmodule

FILE: hw/rtl/double_hash_open_address_table.sv
// Open-addressed hash table with double hashing over one slot RAM.
// Each word carries one command and yields one result word. A resize takes
// the first listed prime above requested_size as the table size P and clears
// slots 0 to P-1, one RAM write per cycle.
// An insert or lookup first runs a bit-serial remainder unit for hash mod P
// and hash mod (P-2), then probes the slot RAM through S_ADDR and S_CHECK per
// slot (address, then registered read data); a lookup miss probes all P slots.
// One command is in work at a time; the result register lets the next word
// in while it waits.
module double_hash_open_address_table
    import dhoat_pkg::*;
#(
    parameter int MAX_SLOTS  = 8192,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    // Configuration: requested_size.
    input  logic          cfg_wr_en,
    input  logic [12:0]   cfg_wr_data,
    // Command words.
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // tdata: key_hash [31:0], key_id [95:32], list_value [111:96].
    input  logic [111:0]  s_axis_tdata,
    // tuser: cmd [1:0].
    input  logic [1:0]    s_axis_tuser,
    // Result words.
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // tdata: found_value [15:0], slot_index [28:16], zero fill [31:29].
    output logic [31:0]   m_axis_tdata,
    // tuser: status [2:0].
    output logic [2:0]    m_axis_tuser
);

    localparam int AW = $clog2(MAX_SLOTS);
    localparam int WW = KEY_BITS + VALUE_BITS + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_DIV,
        S_ADDR,
        S_CHECK,
        S_OUT
    } state_t;

    state_t            state_reg;
    logic [SIZE_W-1:0] req_size_reg;
    logic [SIZE_W-1:0] table_size_reg;
    logic [COUNT_W-1:0] used_count_reg;
    logic              ready_reg;
    logic              is_insert_reg;
    logic [HASH_W-1:0] hash_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic [SIZE_W-1:0] slot_reg;
    logic [SIZE_W-1:0] step_reg;
    logic [SIZE_W-1:0] probe_cnt_reg;
    logic [SIZE_W-1:0] clr_addr_reg;
    result_code_t      res_status_reg;
    logic [15:0]       res_value_reg;
    logic [SIZE_W-1:0] res_slot_reg;
    logic              m_valid_reg;
    logic [2:0]        m_status_reg;
    logic [15:0]       m_value_reg;
    logic [SIZE_W-1:0] m_slot_reg;

    // Input field split.
    logic [1:0]        in_cmd;
    logic [HASH_W-1:0] in_hash;
    logic [63:0]       in_key;
    logic [15:0]       in_value;
    logic [31:0]       in_value_ext;
    logic              in_accept;

    assign in_cmd       = s_axis_tuser;
    assign in_hash      = s_axis_tdata[31:0];
    assign in_key       = s_axis_tdata[95:32];
    assign in_value     = s_axis_tdata[111:96];
    assign in_value_ext = {16'd0, in_value};
    assign in_accept    = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);

    // First listed prime above the requested size.
    logic [SIZE_W-1:0] pick_prime;
    logic              pick_found;
    logic              too_big;

    always_comb
    begin
        pick_prime = '0;
        pick_found = 1'b0;
        for (int i = PRIME_COUNT - 1; i >= 0; i--)
        begin
            if (prime_at(4'(i)) > req_size_reg)
            begin
                pick_prime = prime_at(4'(i));
                pick_found = 1'b1;
            end
        end
        too_big = !pick_found || ({1'b0, pick_prime} > (SIZE_W + 1)'(MAX_SLOTS));
    end

    // Remainder unit for the home slot and the probe step.
    logic              div_start;
    logic              div_done;
    logic [SIZE_W-1:0] rem_home;
    logic [SIZE_W-1:0] rem_step;

    dhoat_rem u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (hash_reg),
        .div_a    (table_size_reg),
        .div_b    (table_size_reg - SIZE_W'(2)),
        .done     (div_done),
        .rem_a    (rem_home),
        .rem_b    (rem_step)
    );

    // Slot RAM: {used, value, key} per entry.
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [WW-1:0] ram_wdata;
    logic [WW-1:0] ram_rdata;

    dhoat_ram #(
        .WIDTH (WW),
        .DEPTH (MAX_SLOTS)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (slot_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // Probe decision on the word read for the current slot.
    logic                  rd_used;
    logic [VALUE_BITS-1:0] rd_value;
    logic [KEY_BITS-1:0]   rd_key;
    logic [31:0]           rd_value_ext;
    logic                  hit;
    logic                  last_probe;
    logic [SIZE_W:0]       slot_sum;
    logic [SIZE_W-1:0]     slot_adv;
    logic                  ins_write;

    assign rd_used      = ram_rdata[WW-1];
    assign rd_value     = ram_rdata[KEY_BITS +: VALUE_BITS];
    assign rd_key       = ram_rdata[KEY_BITS-1:0];
    assign rd_value_ext = 32'(rd_value);
    assign hit          = is_insert_reg ? !rd_used : (rd_used && rd_key == key_reg);
    assign last_probe   = (probe_cnt_reg == table_size_reg - SIZE_W'(1));
    assign slot_sum     = {1'b0, slot_reg} + {1'b0, step_reg};
    assign slot_adv     = (slot_sum >= {1'b0, table_size_reg})
                          ? SIZE_W'(slot_sum - {1'b0, table_size_reg})
                          : slot_sum[SIZE_W-1:0];
    assign ins_write    = (state_reg == S_CHECK) && is_insert_reg && hit;

    // Clear pass and insert share the write port.
    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg[AW-1:0];
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = ins_write;
            ram_waddr = slot_reg[AW-1:0];
            ram_wdata = {1'b1, value_reg, key_reg};
        end
    end

    assign div_start = (state_reg == S_DIV) && !div_done && (probe_cnt_reg == '0)
                       && (clr_addr_reg == '0);

    // Command sequencer and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            req_size_reg   <= '0;
            table_size_reg <= '0;
            used_count_reg <= '0;
            ready_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
            probe_cnt_reg  <= '0;
            clr_addr_reg   <= '0;
            res_status_reg <= ST_OK;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                req_size_reg <= cfg_wr_data;
            end
            // The result word leaves; a new one is loaded only in S_OUT.
            if (m_valid_reg && m_axis_tready && state_reg != S_OUT)
            begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        hash_reg      <= in_hash;
                        key_reg       <= in_key[KEY_BITS-1:0];
                        value_reg     <= in_value_ext[VALUE_BITS-1:0];
                        is_insert_reg <= (in_cmd == CMD_INSERT);
                        res_value_reg <= '0;
                        res_slot_reg  <= '0;
                        probe_cnt_reg <= '0;
                        clr_addr_reg  <= '0;
                        if (in_cmd == CMD_RESIZE)
                        begin
                            if (too_big)
                            begin
                                res_status_reg <= ST_TOO_BIG;
                                state_reg      <= S_OUT;
                            end
                            else
                            begin
                                table_size_reg <= pick_prime;
                                used_count_reg <= '0;
                                ready_reg      <= 1'b1;
                                res_status_reg <= ST_OK;
                                state_reg      <= S_CLEAR;
                            end
                        end
                        else if (in_cmd == CMD_UNUSED || !ready_reg)
                        begin
                            res_status_reg <= ST_NOT_READY;
                            state_reg      <= S_OUT;
                        end
                        else if (in_cmd == CMD_INSERT
                                 && used_count_reg >= {1'b0, table_size_reg})
                        begin
                            res_status_reg <= ST_FULL;
                            state_reg      <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_DIV;
                        end
                    end
                end

                S_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + SIZE_W'(1);
                    if (clr_addr_reg == table_size_reg - SIZE_W'(1))
                    begin
                        state_reg <= S_OUT;
                    end
                end

                S_DIV:
                begin
                    if (div_done)
                    begin
                        slot_reg  <= rem_home;
                        step_reg  <= rem_step + SIZE_W'(1);
                        state_reg <= S_ADDR;
                    end
                    else if (div_start)
                    begin
                        // Mark the unit as launched so it starts only once.
                        clr_addr_reg <= SIZE_W'(1);
                    end
                end

                S_ADDR:
                begin
                    state_reg <= S_CHECK;
                end

                S_CHECK:
                begin
                    if (hit)
                    begin
                        res_status_reg <= ST_OK;
                        res_slot_reg   <= slot_reg;
                        if (is_insert_reg)
                        begin
                            used_count_reg <= used_count_reg + COUNT_W'(1);
                        end
                        else
                        begin
                            res_value_reg <= rd_value_ext[15:0];
                        end
                        state_reg <= S_OUT;
                    end
                    else if (last_probe)
                    begin
                        res_status_reg <= is_insert_reg ? ST_NO_SLOT : ST_NOT_FOUND;
                        state_reg      <= S_OUT;
                    end
                    else
                    begin
                        slot_reg      <= slot_adv;
                        probe_cnt_reg <= probe_cnt_reg + SIZE_W'(1);
                        state_reg     <= S_ADDR;
                    end
                end

                S_OUT:
                begin
                    if (!m_valid_reg || m_axis_tready)
                    begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= res_status_reg;
                        m_value_reg  <= res_value_reg;
                        m_slot_reg   <= res_slot_reg;
                        state_reg    <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_status_reg;
    assign m_axis_tdata  = {3'b000, m_slot_reg, m_value_reg};

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the double-hash open-addressed table.
`timescale 1ns / 1ps

module testbench;
    import dhoat_pkg::*;

    // One expected result word.
    typedef struct {
        result_code_t status;
        logic [15:0]  found;
        logic [12:0]  slot;
    } outcome_t;

    // Table predictor with a queue of outcomes still to arrive.
    class table_scoreboard;
        logic [63:0] key_at[8192];
        logic [15:0] value_at[8192];
        bit          busy_at[8192];
        int unsigned size_now;
        int unsigned entries;
        bit          ready;
        int unsigned wanted;
        outcome_t    outcomes[$];
        int          fail_count;

        function new();
            foreach (busy_at[i]) busy_at[i] = 0;
            size_now = 0;
            entries = 0;
            ready = 0;
            wanted = 0;
            fail_count = 0;
        endfunction

        // Walk the double-hash sequence for a free slot or a matching key.
        function int walk(logic [31:0] h, logic [63:0] k, bit want_free);
            int unsigned s;
            int unsigned stride;
            s = h % size_now;
            stride = 1 + h % (size_now - 2);
            for (int unsigned n = 0; n < size_now; n++)
            begin
                if (want_free && !busy_at[s])
                    return s;
                if (!want_free && busy_at[s] && key_at[s] == k)
                    return s;
                s = s + stride;
                if (s >= size_now)
                    s = s - size_now;
            end
            return -1;
        endfunction

        // Apply one accepted command word and queue its outcome.
        function void note_word(cmd_t c, logic [31:0] h, logic [63:0] k, logic [15:0] v);
            int unsigned primes[16] = '{127, 251, 509, 761, 1021, 1279, 1531, 1789,
                                        2039, 2557, 3067, 4093, 5119, 6143, 7159, 8191};
            int unsigned p;
            int s;
            outcome_t o;
            o.status = ST_OK;
            o.found = '0;
            o.slot = '0;
            if (c == CMD_RESIZE)
            begin
                p = 0;
                foreach (primes[i])
                    if (p == 0 && primes[i] > wanted)
                        p = primes[i];
                if (p == 0 || p > 8192)
                    o.status = ST_TOO_BIG;
                else
                begin
                    foreach (busy_at[i]) busy_at[i] = 0;
                    size_now = p;
                    entries = 0;
                    ready = 1;
                end
            end
            else if (c == CMD_UNUSED || !ready)
                o.status = ST_NOT_READY;
            else if (c == CMD_INSERT)
            begin
                if (entries >= size_now)
                    o.status = ST_FULL;
                else
                begin
                    s = walk(h, k, 1);
                    if (s < 0)
                        o.status = ST_NO_SLOT;
                    else
                    begin
                        key_at[s] = k;
                        value_at[s] = v;
                        busy_at[s] = 1;
                        entries++;
                        o.slot = 13'(s);
                    end
                end
            end
            else
            begin
                s = walk(h, k, 0);
                if (s < 0)
                    o.status = ST_NOT_FOUND;
                else
                begin
                    o.found = value_at[s];
                    o.slot = 13'(s);
                end
            end
            outcomes.push_back(o);
        endfunction

        // Compare one result word with the oldest outcome.
        function void check_word(logic [31:0] d, logic [2:0] u);
            outcome_t o;
            if (outcomes.size() == 0)
            begin
                $error("result word with nothing expected: status %0d", u);
                fail_count++;
                return;
            end
            o = outcomes.pop_front();
            if (u !== o.status)
            begin
                $error("status: expected %0d, got %0d", o.status, u);
                fail_count++;
            end
            if (d[15:0] !== o.found)
            begin
                $error("found_value: expected %0d, got %0d", o.found, d[15:0]);
                fail_count++;
            end
            if (d[28:16] !== o.slot)
            begin
                $error("slot_index: expected %0d, got %0d", o.slot, d[28:16]);
                fail_count++;
            end
        endfunction
    endclass

    logic          clk;
    logic          rst_n;
    logic          cfg_wr_en;
    logic [12:0]   cfg_wr_data;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [111:0]  s_axis_tdata;
    logic [1:0]    s_axis_tuser;
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [31:0]   m_axis_tdata;
    logic [2:0]    m_axis_tuser;

    table_scoreboard sb;
    bit            src_idle;
    bit            sink_idle;
    int            hold_left;
    int            words_sent;
    logic [31:0]   known_hash[$];
    logic [63:0]   known_key[$];

    double_hash_open_address_table u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock generation.
    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Overall time limit.
    initial
    begin
        #200ms;
        $display("FAIL double_hash_open_address_table");
        $finish;
    end

    // Result side: check accepted words and drive ready with stalls.
    initial
    begin
        m_axis_tready = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_word(m_axis_tdata, m_axis_tuser);
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 0;
            end
            else
                m_axis_tready <= !(sink_idle && $urandom_range(99) < 8);
        end
    end

    // Offer one command word and wait until it is taken.
    task automatic send_word(cmd_t c, logic [31:0] h, logic [63:0] k, logic [15:0] v);
        while (src_idle && $urandom_range(99) < 8)
        begin
            s_axis_tvalid <= 0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser <= c;
        s_axis_tdata <= {v, k, h};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_word(c, h, k, v);
        words_sent++;
        if (c == CMD_INSERT)
        begin
            known_hash.push_back(h);
            known_key.push_back(k);
        end
        if (c == CMD_RESIZE)
        begin
            known_hash.delete();
            known_key.delete();
        end
    endtask

    // Stop offering and wait until every expected word has come back.
    task automatic drain();
        s_axis_tvalid <= 0;
        @(posedge clk);
        while (sb.outcomes.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
    endtask

    // Write requested_size while the block is idle.
    task automatic set_size(int unsigned n);
        cfg_wr_en <= 1;
        cfg_wr_data <= 13'(n);
        @(posedge clk);
        cfg_wr_en <= 0;
        sb.wanted = n;
        @(posedge clk);
    endtask

    // One random command, mostly inserts and lookups, many of them hits.
    task automatic random_word();
        int r;
        int j;
        logic [31:0] h;
        logic [63:0] k;
        r = $urandom_range(99);
        h = $urandom;
        k = {$urandom, $urandom};
        if (r < 3)
            send_word(CMD_RESIZE, h, k, 16'($urandom));
        else if (r < 6)
            send_word(CMD_UNUSED, h, k, 16'($urandom));
        else if (r < 50)
        begin
            // Occasional duplicate key.
            if (known_key.size() != 0 && $urandom_range(9) == 0)
            begin
                j = $urandom_range(known_key.size() - 1);
                h = known_hash[j];
                k = known_key[j];
            end
            send_word(CMD_INSERT, h, k, 16'($urandom));
        end
        else
        begin
            if (known_key.size() != 0 && $urandom_range(99) < 75)
            begin
                j = $urandom_range(known_key.size() - 1);
                h = known_hash[j];
                k = known_key[j];
                // Same probe path, different key.
                if ($urandom_range(9) == 0)
                    k[$urandom_range(63)] ^= 1'b1;
            end
            send_word(CMD_LOOKUP, h, k, 16'($urandom));
        end
    endtask

    // Main sequence.
    initial
    begin
        int phase;
        sb = new();
        rst_n = 0;
        cfg_wr_en = 0;
        cfg_wr_data = '0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        s_axis_tuser = CMD_INSERT;
        src_idle = 0;
        sink_idle = 0;
        hold_left = 0;
        words_sent = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Commands before any table exists, then a smallest table.
        set_size(0);
        send_word(CMD_INSERT, 32'h1, 64'h5, 16'h7);
        send_word(CMD_LOOKUP, 32'h1, 64'h5, 16'h0);
        send_word(CMD_UNUSED, 32'hFFFF_FFFF, '1, '1);
        send_word(CMD_RESIZE, '0, '0, '0);
        send_word(CMD_INSERT, 32'h0, 64'h0, 16'h0);
        send_word(CMD_INSERT, 32'hFFFF_FFFF, '1, 16'hFFFF);
        send_word(CMD_INSERT, 32'hFFFF_FFFF, 64'h1234, 16'hA5A5);
        send_word(CMD_INSERT, 32'hFFFF_FFFF, '1, 16'h5A5A);
        send_word(CMD_LOOKUP, 32'hFFFF_FFFF, '1, '0);
        send_word(CMD_LOOKUP, 32'h0, 64'h0, '0);
        send_word(CMD_LOOKUP, 32'hFFFF_FFFF, 64'h1234, '0);
        send_word(CMD_LOOKUP, 32'h0, 64'h99, '0);
        send_word(CMD_UNUSED, '0, '0, '0);
        drain();

        // Too big a request leaves the table as it was.
        set_size(8191);
        send_word(CMD_RESIZE, '0, '0, '0);
        send_word(CMD_LOOKUP, 32'hFFFF_FFFF, 64'h1234, '0);
        drain();

        // Fill a 127-slot table past its end, without idling on either side.
        set_size(126);
        send_word(CMD_RESIZE, '0, '0, '0);
        for (int i = 0; i < 130; i++)
            send_word(CMD_INSERT, $urandom, {$urandom, $urandom}, 16'($urandom));
        for (int i = 0; i < 10; i++)
            random_word();
        drain();

        // Largest table, a few words only.
        set_size(8190);
        send_word(CMD_RESIZE, '0, '0, '0);
        send_word(CMD_INSERT, 32'hFFFF_FFFF, 64'hDEAD, 16'h1);
        send_word(CMD_INSERT, 32'h0, 64'hBEEF, 16'h2);
        send_word(CMD_LOOKUP, 32'hFFFF_FFFF, 64'hDEAD, '0);
        send_word(CMD_LOOKUP, 32'h0, 64'hBEEF, '0);
        send_word(CMD_LOOKUP, 32'h7, 64'h1, '0);
        drain();

        // Random phases over small tables, with stalls on both sides.
        src_idle = 1;
        sink_idle = 1;
        phase = 0;
        while (words_sent < 1400)
        begin
            if (phase % 4 == 3)
                set_size($urandom_range(8191));
            else if (phase == 2)
                set_size(100);
            else
                set_size($urandom_range(300));
            if (sb.wanted > 260)
                send_word(CMD_RESIZE, '0, '0, '0);
            else
            begin
                send_word(CMD_RESIZE, '0, '0, '0);
                if (phase == 2)
                    hold_left = 600;
                for (int i = 0; i < 80; i++)
                    random_word();
            end
            drain();
            phase++;
        end

        drain();
        repeat (100) @(posedge clk);
        if (sb.fail_count == 0 && sb.outcomes.size() == 0)
            $display("PASS double_hash_open_address_table");
        else
            $display("FAIL double_hash_open_address_table");
        $finish;
    end

endmodule
